// ----- rtl/tmh_pkg.sv -----
// ----------------------------------------------------------------------------
// tmh_pkg: shared types and constants of the priority queue
// Sizes, operation and status codes, the word held by one cell and the
// signed key order used by every cell.
// ----------------------------------------------------------------------------
package tmh_pkg;

  localparam int unsigned HEAP_DEPTH = 64;
  localparam int unsigned KEY_WIDTH  = 32;
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 7;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_EXTRACT
  } cmd_e;

  // One entry of the sorted chain
  typedef struct packed {
    logic valid;
    key_t key;
  } cell_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cmd_e cmd;
    key_t key;
  } cell_ctrl_t;

  // Keys order as signed integers of KEY_WIDTH bits
  function automatic logic key_less(key_t a, key_t b);
    return $signed(a) < $signed(b);
  endfunction

  // Take the key bits out of the input value field
  function automatic key_t key_from_field(logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[KEY_WIDTH-1:0];
  endfunction

  // Place a raw key into the result field, zero filled above the key
  function automatic logic [VALUE_W-1:0] key_to_field(key_t k);
    logic [63:0] w;
    w = 64'(k);
    return w[VALUE_W-1:0];
  endfunction

endpackage

// ----- rtl/ternary_min_heap_top.sv -----
// ----------------------------------------------------------------------------
// ternary_min_heap_top: min-priority queue of signed keys
// Input channel carries a mode (insert or extract minimum) and a key; the
// output channel returns one word per input word: the removed minimum, a
// status (ok, full, empty) and the number of entries held afterwards.
//
// Keys sit in a row of cells in ascending order, so the minimum is always
// in the first cell. Every operation is a single update of the whole row: all cells
// compare the new key at once and each cell takes its neighbour's word.
// An input word is taken in the cycle it is offered, and its result sits
// in the output register from the next cycle. The queue takes one word
// per cycle while the receiver does not stall the output register.
//
// Reset empties the queue (valid flags and count cleared) and drops any
// pending result. While the receiver stalls, the result is held in the
// output register and the input side stops taking words until it leaves.
// Insert into a full queue is refused; extract from an empty queue
// returns the empty status with a zero key.
// ----------------------------------------------------------------------------
module ternary_min_heap_top
  import tmh_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [VALUE_W-1:0]  min_value_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic        [COUNT_W-1:0]  count_o
);

  cell_ctrl_t ctrl;
  cell_t      head;

  logic accept;
  logic full, empty;

  cnt_t cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] min_q, min_d;
  status_e status_q, status_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CNT_W'(HEAP_DEPTH));
  assign empty      = (cnt_q == '0);

  // Decode the operation and build the result word
  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.key    = key_from_field($unsigned(value_i));
    cnt_d       = cnt_q;
    min_d       = min_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      out_valid_d = 1'b1;
      min_d       = '0;
      status_d    = STAT_OK;
      unique case (mode_e'(mode_i))
        MODE_INSERT: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.cmd = CMD_INSERT;
            cnt_d    = cnt_q + cnt_t'(1);
          end
        end
        MODE_EXTRACT: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            ctrl.cmd = CMD_EXTRACT;
            min_d    = key_to_field(head.key);
            cnt_d    = cnt_q - cnt_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  tmh_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  // Hold the count and the result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign min_value_o = $signed(min_q);
  assign status_o    = status_q;
  assign count_o     = COUNT_W'(cnt_q);

endmodule

// ----- rtl/tmh_cell.sv -----
// ----------------------------------------------------------------------------
// tmh_cell: one entry of the sorted key chain
// Holds a key and its valid flag. On insert it takes its left neighbour's
// word or the new key; on extract it takes its right neighbour's word.
// ----------------------------------------------------------------------------
module tmh_cell
  import tmh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_t      left_i,
  input  logic       left_lt_i,
  input  cell_t      right_i,
  output cell_t      cell_o,
  output logic       lt_o
);

  logic valid_q, valid_d;
  key_t key_q, key_d;

  // New key belongs at or before this cell: empty cells count as infinity
  assign lt_o = !valid_q || key_less(ctrl_i.key, key_q);

  // Select the next word for this cell
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (left_lt_i) begin
          valid_d = left_i.valid;
          key_d   = left_i.key;
        end else if (lt_o) begin
          valid_d = 1'b1;
          key_d   = ctrl_i.key;
        end
      end
      CMD_EXTRACT: begin
        valid_d = right_i.valid;
        key_d   = right_i.key;
      end
      default: begin
      end
    endcase
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the key
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.key   = key_q;

endmodule

// ----- rtl/tmh_chain.sv -----
// ----------------------------------------------------------------------------
// tmh_chain: row of cells kept in ascending key order
// Cell zero always holds the smallest key. Insert shifts the tail of the
// row right by one; extract shifts the whole row left by one.
// ----------------------------------------------------------------------------
module tmh_chain
  import tmh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  output cell_t      head_o
);

  cell_t cells [HEAP_DEPTH];
  logic  lt    [HEAP_DEPTH];

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    cell_t left_w, right_w;
    logic  left_lt_w;

    // Tie off the ends of the row
    if (i == 0) begin : g_first
      assign left_w    = '0;
      assign left_lt_w = 1'b0;
    end else begin : g_inner_l
      assign left_w    = cells[i-1];
      assign left_lt_w = lt[i-1];
    end

    if (i == HEAP_DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cells[i+1];
    end

    tmh_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .left_i    (left_w),
      .left_lt_i (left_lt_w),
      .right_i   (right_w),
      .cell_o    (cells[i]),
      .lt_o      (lt[i])
    );
  end

  assign head_o = cells[0];

endmodule

// ----- rtl/tmh_checker.sv -----
// ----------------------------------------------------------------------------
// tmh_checker: port-level checks of the priority queue
// Watches the top level's ports and flags results that contradict the
// queue's own rules on status, count and flow control.
// ----------------------------------------------------------------------------
module tmh_checker
  import tmh_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [VALUE_W-1:0]  min_value_o,
  input logic        [STATUS_W-1:0] status_o,
  input logic        [COUNT_W-1:0]  count_o
);

  // Flag a stalled result that changes before it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(min_value_o) && $stable(status_o) && $stable(count_o))
    else $error("result word changed while stalled");

  // Flag a full status without a full queue or with a nonzero key
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |->
      count_o == COUNT_W'(HEAP_DEPTH) && min_value_o == '0)
    else $error("full status with queue not full");

  // Flag an empty status that reports entries or a key
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> count_o == '0 && min_value_o == '0)
    else $error("empty status with entries or key");

  // Flag a stall of the input side while the output register is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with free output register");

endmodule

bind ternary_min_heap_top tmh_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .min_value_o (min_value_o),
  .status_o    (status_o),
  .count_o     (count_o)
);
